@@ rtl/core/keyed_fifo_queue_assert.svh @@
// assertion macros for the keyed fifo queue rtl
`ifndef KEYED_FIFO_QUEUE_ASSERT_SVH
`define KEYED_FIFO_QUEUE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define KFQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define KFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/kfq_pkg.sv @@
// types, sizes and codes of the keyed fifo queue
package kfq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OCC_W = 5;

    typedef enum logic [1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_SEARCH = 2'd2,
        ACT_DELETE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_POP_READ,
        ST_SCAN,
        ST_SHIFT,
        ST_REPLY
    } state_t;

    typedef struct packed {
        logic [31:0] key;
        logic [15:0] name_ref;
        logic [15:0] text_ref;
        logic [30:0] price;
        logic [30:0] buy_now;
    } rec_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        rec_t             wdata;
        logic [IDX_W-1:0] raddr;
    } mem_cmd_t;

    typedef struct packed {
        status_t status;
        rec_t    rec;
    } res_t;

    typedef struct packed {
        status_t          status;
        rec_t             rec;
        logic [OCC_W-1:0] occ;
    } rsp_t;

endpackage

@@ rtl/core/kfq_if.sv @@
// request and response channel interfaces of the keyed fifo queue
interface kfq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] key;
    logic [15:0] name_ref;
    logic [15:0] text_ref;
    logic [30:0] price;
    logic [30:0] buy_now_price;

    modport source (
        output valid, action, key, name_ref, text_ref, price, buy_now_price,
        input  ready
    );
    modport sink (
        input  valid, action, key, name_ref, text_ref, price, buy_now_price,
        output ready
    );
endinterface

interface kfq_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] out_key;
    logic [15:0] out_name_ref;
    logic [15:0] out_text_ref;
    logic [30:0] out_price;
    logic [30:0] out_buy_now;
    logic [4:0]  occupancy;

    modport source (
        output valid, status, out_key, out_name_ref, out_text_ref, out_price,
               out_buy_now, occupancy,
        input  ready
    );
    modport sink (
        input  valid, status, out_key, out_name_ref, out_text_ref, out_price,
               out_buy_now, occupancy,
        output ready
    );
endinterface

@@ rtl/core/kfq_store.sv @@
// record store: one write port and one registered read port
module kfq_store (
    input  logic             clk,
    input  kfq_pkg::mem_cmd_t cmd,
    output kfq_pkg::rec_t     rd_data
);
    import kfq_pkg::*;

    rec_t mem [DEPTH];
    rec_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[cmd.waddr] <= cmd.wdata;
        end
        rd_data_reg <= mem[cmd.raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/kfq_ctrl.sv @@
// sequencer with the shared key comparator, ring pointers and response register
`include "keyed_fifo_queue_assert.svh"

module kfq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    kfq_req_if.sink           req,
    kfq_rsp_if.source         rsp,
    output kfq_pkg::mem_cmd_t mem_cmd,
    input  kfq_pkg::rec_t     rd_data
);
    import kfq_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    action_t          act_reg;
    logic [31:0]      key_reg;
    rec_t             push_rec_reg;
    res_t             res_reg, res_next;
    logic             out_valid_reg;
    rsp_t             out_reg;

    logic [CNT_W:0]   cnt_ext;
    logic [CNT_W:0]   idx1;
    logic [CNT_W:0]   idx2;
    logic             is_full;
    logic             is_empty;
    logic             key_hit;
    logic             last_hit;
    logic             shift_end;
    logic             out_free;
    logic             req_take;
    logic [31:0]      cnt_wide;

    // ring position of a logical offset from the front
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                              input logic [CNT_W:0] ofs);
        logic [CNT_W+1:0] s;
        s = (CNT_W+2)'(base) + (CNT_W+2)'(ofs);
        if (s >= (CNT_W+2)'(DEPTH))
        begin
            s = s - (CNT_W+2)'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    assign cnt_ext   = {1'b0, count_reg};
    assign idx1      = (CNT_W+1)'(idx_reg) + (CNT_W+1)'(1);
    assign idx2      = (CNT_W+1)'(idx_reg) + (CNT_W+1)'(2);
    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign key_hit   = (rd_data.key == key_reg);
    assign last_hit  = (idx1 == cnt_ext);
    assign shift_end = (idx2 == cnt_ext);
    assign out_free  = !out_valid_reg || rsp.ready;
    assign req_take  = req.valid && req.ready;
    assign cnt_wide  = 32'(count_reg);

    assign req.ready = (state_reg == ST_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (act_reg)
                    ACT_PUSH:   state_next = ST_REPLY;
                    ACT_POP:    state_next = is_empty ? ST_REPLY : ST_POP_READ;
                    ACT_SEARCH,
                    ACT_DELETE: state_next = is_empty ? ST_REPLY : ST_SCAN;
                    default:    state_next = ST_REPLY;
                endcase
            end
            ST_POP_READ:
            begin
                state_next = ST_REPLY;
            end
            ST_SCAN:
            begin
                if (key_hit && (act_reg == ACT_SEARCH))
                begin
                    state_next = ST_REPLY;
                end
                else if (key_hit)
                begin
                    state_next = last_hit ? ST_REPLY : ST_SHIFT;
                end
                else if (last_hit)
                begin
                    state_next = ST_REPLY;
                end
            end
            ST_SHIFT:
            begin
                if (shift_end)
                begin
                    state_next = ST_REPLY;
                end
            end
            ST_REPLY:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and store commands
    always_comb
    begin
        count_next    = count_reg;
        head_next     = head_reg;
        idx_next      = idx_reg;
        res_next      = res_reg;
        mem_cmd.we    = 1'b0;
        mem_cmd.waddr = phys(head_reg, (CNT_W+1)'(idx_reg));
        mem_cmd.wdata = rd_data;
        mem_cmd.raddr = phys(head_reg, idx1);
        unique case (state_reg)
            ST_DISPATCH:
            begin
                idx_next        = '0;
                mem_cmd.raddr   = head_reg;
                res_next.rec    = '0;
                res_next.status = STATUS_OK;
                unique case (act_reg)
                    ACT_PUSH:
                    begin
                        if (is_full)
                        begin
                            res_next.status = STATUS_FULL;
                        end
                        else
                        begin
                            mem_cmd.we    = 1'b1;
                            mem_cmd.waddr = phys(head_reg, cnt_ext);
                            mem_cmd.wdata = push_rec_reg;
                            count_next    = count_reg + CNT_W'(1);
                        end
                    end
                    ACT_POP:
                    begin
                        if (is_empty)
                        begin
                            res_next.status = STATUS_EMPTY;
                        end
                    end
                    ACT_SEARCH,
                    ACT_DELETE:
                    begin
                        if (is_empty)
                        begin
                            res_next.status = STATUS_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        res_next.status = STATUS_OK;
                    end
                endcase
            end
            ST_POP_READ:
            begin
                res_next.rec = rd_data;
                head_next    = phys(head_reg, (CNT_W+1)'(1));
                count_next   = count_reg - CNT_W'(1);
            end
            ST_SCAN:
            begin
                if (key_hit && (act_reg == ACT_SEARCH))
                begin
                    res_next.rec = rd_data;
                end
                else if (key_hit)
                begin
                    if (last_hit)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                else if (last_hit)
                begin
                    res_next.status = STATUS_NOT_FOUND;
                end
                else
                begin
                    idx_next = IDX_W'(idx1);
                end
            end
            ST_SHIFT:
            begin
                mem_cmd.we    = 1'b1;
                mem_cmd.raddr = phys(head_reg, idx2);
                idx_next      = IDX_W'(idx1);
                if (shift_end)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ST_IDLE,
            ST_REPLY:
            begin
                res_next = res_reg;
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            head_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            idx_reg   <= idx_next;
        end
    end

    // request capture and working result
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            act_reg               <= action_t'(req.action);
            key_reg               <= req.key;
            push_rec_reg.key      <= req.key;
            push_rec_reg.name_ref <= req.name_ref;
            push_rec_reg.text_ref <= req.text_ref;
            push_rec_reg.price    <= req.price;
            push_rec_reg.buy_now  <= req.buy_now_price;
        end
        res_reg <= res_next;
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_REPLY) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_REPLY) && out_free)
        begin
            out_reg.status <= res_reg.status;
            out_reg.rec    <= res_reg.rec;
            out_reg.occ    <= cnt_wide[OCC_W-1:0];
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_reg.status;
    assign rsp.out_key      = out_reg.rec.key;
    assign rsp.out_name_ref = out_reg.rec.name_ref;
    assign rsp.out_text_ref = out_reg.rec.text_ref;
    assign rsp.out_price    = out_reg.rec.price;
    assign rsp.out_buy_now  = out_reg.rec.buy_now;
    assign rsp.occupancy    = out_reg.occ;

    `KFQ_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "count above depth")
    `KFQ_ASSERT_SAME(a_write_source, mem_cmd.we, (state_reg == ST_SHIFT) || ((state_reg == ST_DISPATCH) && (act_reg == ACT_PUSH)), "unexpected store write")
    `KFQ_ASSERT_NEXT(a_pop_count, state_reg == ST_POP_READ, count_reg == CNT_W'($past(count_reg) - CNT_W'(1)), "pop did not drop count")
    `KFQ_ASSERT_SAME(a_scan_range, state_reg == ST_SCAN, idx1 <= cnt_ext, "scan beyond last record")
    `KFQ_ASSERT_NEXT(a_reply_load, (state_reg == ST_REPLY) && out_free, (state_reg == ST_IDLE) && out_valid_reg, "response not loaded")

endmodule

@@ rtl/core/keyed_fifo_queue.sv @@
// keyed fifo queue top level: ring-ordered record store with keyed search and delete
// Each request is worked by one sequencer that makes one key compare or one record move per
// cycle through the single read and single write port of the record store. After acceptance
// a push and every empty case pass the dispatch and reply states, a pop also reads the front
// record, a search scans from the front until the match, a miss scans every record, and a
// delete scans to the match, then moves each later record down one place to close the gap.
// The response sits in an output register, so the next request is taken while it waits;
// a second response holds in the reply state until the first one has been taken.
module keyed_fifo_queue (
    input  logic      clk,
    input  logic      rst_n,
    kfq_req_if.sink   req,
    kfq_rsp_if.source rsp
);
    import kfq_pkg::*;

    mem_cmd_t mem_cmd;
    rec_t     rd_data;

    kfq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .mem_cmd (mem_cmd),
        .rd_data (rd_data)
    );

    kfq_store u_store (
        .clk     (clk),
        .cmd     (mem_cmd),
        .rd_data (rd_data)
    );

endmodule
